// ===== rtl/snf_pkg.sv =====
// ----------------------------------------------------------------------------
// snf_pkg
// Shared types, constants and helpers for the SEI NAL unit framer.
// ----------------------------------------------------------------------------
package snf_pkg;

    localparam int MAX_PAYLOAD_BYTES = 1023;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int FF_W    = 3;
    localparam int ZRUN_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register indexes (paddr[2])
    localparam logic CFG_CODEC  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 10'd32;

    localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE    = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_H264   = 8'h06;
    localparam logic [BYTE_W-1:0] BYTE_H265   = 8'h4E;
    localparam logic [BYTE_W-1:0] BYTE_TYPE   = 8'h05;
    localparam logic [BYTE_W-1:0] BYTE_FF     = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ESCAPE = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_TRAIL  = 8'h80;

    // Work planned for one payload beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;
        logic              codec;
        logic [FF_W-1:0]   ff_count;
        logic [BYTE_W-1:0] rest;
        logic              esc;
        logic              trail;
    } snf_plan_t;

    // Length after the zero and upper limits
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0)
            r = LEN_W'(1);
        if (int'(v) > MAX_PAYLOAD_BYTES)
            r = LEN_W'(MAX_PAYLOAD_BYTES);
        return r;
    endfunction

    // Number of FF bytes in the size field
    function automatic logic [FF_W-1:0] ff_of(input logic [LEN_W-1:0] len);
        logic [FF_W-1:0] r;
        r = '0;
        if (len >= LEN_W'(255))  r = FF_W'(1);
        if (len >= LEN_W'(510))  r = FF_W'(2);
        if (len >= LEN_W'(765))  r = FF_W'(3);
        if (len >= LEN_W'(1020)) r = FF_W'(4);
        return r;
    endfunction

endpackage

// ===== rtl/sei_nal_unit_framer.sv =====
// ----------------------------------------------------------------------------
// sei_nal_unit_framer
// Frames raw SEI payload bytes into Annex B SEI NAL units with emulation
// prevention.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one raw payload byte per beat; m_* carries the framed unit
//   one byte per beat, m_tlast marking the trailing 80 byte of each unit.
//   The first payload beat of a unit expands to the start code, NAL header
//   (one byte for H.264, two for H.265), payload type and size field ahead of
//   the byte itself; an escape byte may precede any payload byte, and the
//   last payload beat of a unit is followed by the trailing byte.
//   Accepted beats pass the pending, current-plan and output registers in turn.
//   Throughput: one output beat per cycle while m_tready allows; a payload
//   beat expands to 1 to 13 bytes, so plain payload bytes flow at one per
//   cycle. The byte sequencer in the emitter sets this figure.
//   Reset clears the unit position, zero run and all pending beats; the
//   registers return to H.264 and a length of 32.
//   When m_tready is low the output beat holds, the beat being expanded holds
//   in the emitter, one further beat waits in the planner and s_tready drops.
//   Registers (APB): 0x0 codec_select, 0x4 payload_length.
// ----------------------------------------------------------------------------
module sei_nal_unit_framer import snf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,     // [7:0] payload_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,     // [7:0] out_byte
    output logic              m_tlast,     // unit_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic             codec_reg;
    logic [LEN_W-1:0] length_reg;
    logic             wr_en;
    logic             pend_valid;
    logic             pend_take;
    snf_plan_t        pend_plan;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg  <= 1'b0;
            length_reg <= LENGTH_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                CFG_CODEC:  codec_reg  <= pwdata[0];
                CFG_LENGTH: length_reg <= pwdata[LEN_W-1:0];
                default:    codec_reg  <= codec_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_CODEC:  prdata = {{(APB_DW-1){1'b0}}, codec_reg};
            CFG_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, length_reg};
            default:    prdata = '0;
        endcase
    end

    snf_planner u_planner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .codec      (codec_reg),
        .length     (length_reg),
        .pend_take  (pend_take),
        .pend_valid (pend_valid),
        .pend_plan  (pend_plan)
    );

    snf_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pend_valid (pend_valid),
        .pend_plan  (pend_plan),
        .pend_take  (pend_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/snf_planner.sv =====
// ----------------------------------------------------------------------------
// snf_planner
// Takes payload beats, tracks unit position and zero run, and holds the plan
// of output bytes for one beat until the emitter takes it.
// ----------------------------------------------------------------------------
module snf_planner import snf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,     // [7:0] payload_byte
    input  logic              codec,
    input  logic [LEN_W-1:0]  length,
    input  logic              pend_take,
    output logic              pend_valid,
    output snf_plan_t         pend_plan
);

    logic              pend_valid_reg;
    snf_plan_t         pend_plan_reg;
    snf_plan_t         plan_next;
    logic [LEN_W-1:0]  bytes_taken_reg, bytes_taken_next;
    logic [ZRUN_W-1:0] zero_run_reg, zero_run_next;
    logic              accept;

    assign s_tready   = !pend_valid_reg || pend_take;
    assign accept     = s_tvalid && s_tready;
    assign pend_valid = pend_valid_reg;
    assign pend_plan  = pend_plan_reg;

    always_comb begin
        logic [LEN_W-1:0]  len;
        logic [FF_W-1:0]   ffc;
        logic [BYTE_W-1:0] rest;
        logic [ZRUN_W-1:0] zr;
        logic [LEN_W-1:0]  bt;
        logic              hdr;
        logic              esc;
        logic              trail;

        len  = eff_len(length);
        ffc  = ff_of(len);
        rest = BYTE_W'(len - LEN_W'(255 * int'(ffc)));
        hdr  = (bytes_taken_reg == '0);

        // a zero remainder byte counts toward the next escape
        zr = hdr ? ((rest == '0) ? ZRUN_W'(1) : '0) : zero_run_reg;
        esc = (zr >= ZRUN_W'(2)) && (s_tdata <= BYTE_ESCAPE);
        if (esc)
            zr = '0;
        if (s_tdata == BYTE_ZERO) begin
            if (zr < ZRUN_W'(2))
                zr = zr + ZRUN_W'(1);
        end else begin
            zr = '0;
        end

        bt    = bytes_taken_reg + LEN_W'(1);
        trail = (bt >= len) || (bt == '0);
        if (trail) begin
            bt = '0;
            zr = '0;
        end

        plan_next.data     = s_tdata;
        plan_next.hdr      = hdr;
        plan_next.codec    = codec;
        plan_next.ff_count = ffc;
        plan_next.rest     = rest;
        plan_next.esc      = esc;
        plan_next.trail    = trail;
        bytes_taken_next   = bt;
        zero_run_next      = zr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg  <= 1'b0;
            bytes_taken_reg <= '0;
            zero_run_reg    <= '0;
        end else begin
            if (accept) begin
                pend_valid_reg  <= 1'b1;
                bytes_taken_reg <= bytes_taken_next;
                zero_run_reg    <= zero_run_next;
            end else if (pend_take) begin
                pend_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            pend_plan_reg <= plan_next;
    end

endmodule

// ===== rtl/snf_emitter.sv =====
// ----------------------------------------------------------------------------
// snf_emitter
// Walks the plan of each payload beat and drives one output byte per cycle
// through the result register whenever that register is free.
// ----------------------------------------------------------------------------
module snf_emitter import snf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pend_valid,
    input  snf_plan_t         pend_plan,
    output logic              pend_take,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,     // [7:0] out_byte
    output logic              m_tlast      // unit_end
);

    localparam logic [3:0] SL_SC0   = 4'd0;
    localparam logic [3:0] SL_SC1   = 4'd1;
    localparam logic [3:0] SL_SC2   = 4'd2;
    localparam logic [3:0] SL_SC3   = 4'd3;
    localparam logic [3:0] SL_HDR0  = 4'd4;
    localparam logic [3:0] SL_HDR1  = 4'd5;
    localparam logic [3:0] SL_TYPE  = 4'd6;
    localparam logic [3:0] SL_FF    = 4'd7;
    localparam logic [3:0] SL_REST  = 4'd8;
    localparam logic [3:0] SL_ESC   = 4'd9;
    localparam logic [3:0] SL_DATA  = 4'd10;
    localparam logic [3:0] SL_TRAIL = 4'd11;
    localparam logic [3:0] SL_DONE  = 4'd12;

    logic              cur_valid_reg;
    snf_plan_t         cur_plan_reg;
    logic [3:0]        slot_reg, slot_next;
    logic [FF_W-1:0]   ff_left_reg, ff_left_next;
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;

    logic              out_free;
    logic              emit;
    logic              last;
    logic [BYTE_W-1:0] slot_byte;
    logic [3:0]        first_slot;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = out_free && cur_valid_reg;
    assign last      = (slot_next == SL_DONE);
    assign pend_take = pend_valid && (!cur_valid_reg || (emit && last));

    assign first_slot = pend_plan.hdr ? SL_SC0 : (pend_plan.esc ? SL_ESC : SL_DATA);

    always_comb begin
        slot_byte    = BYTE_ZERO;
        slot_next    = SL_DONE;
        ff_left_next = ff_left_reg;
        case (slot_reg)
            SL_SC0: slot_next = SL_SC1;
            SL_SC1: slot_next = SL_SC2;
            SL_SC2: slot_next = SL_SC3;
            SL_SC3: begin
                slot_byte = BYTE_ONE;
                slot_next = SL_HDR0;
            end
            SL_HDR0: begin
                slot_byte = cur_plan_reg.codec ? BYTE_H265 : BYTE_H264;
                slot_next = cur_plan_reg.codec ? SL_HDR1 : SL_TYPE;
            end
            SL_HDR1: begin
                slot_byte = BYTE_ONE;
                slot_next = SL_TYPE;
            end
            SL_TYPE: begin
                slot_byte = BYTE_TYPE;
                slot_next = (ff_left_reg != '0) ? SL_FF : SL_REST;
            end
            SL_FF: begin
                slot_byte    = BYTE_FF;
                ff_left_next = ff_left_reg - FF_W'(1);
                slot_next    = (ff_left_reg == FF_W'(1)) ? SL_REST : SL_FF;
            end
            SL_REST: begin
                slot_byte = cur_plan_reg.rest;
                slot_next = cur_plan_reg.esc ? SL_ESC : SL_DATA;
            end
            SL_ESC: begin
                slot_byte = BYTE_ESCAPE;
                slot_next = SL_DATA;
            end
            SL_DATA: begin
                slot_byte = cur_plan_reg.data;
                slot_next = cur_plan_reg.trail ? SL_TRAIL : SL_DONE;
            end
            SL_TRAIL: begin
                slot_byte = BYTE_TRAIL;
                slot_next = SL_DONE;
            end
            default: slot_next = SL_DONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            slot_reg      <= SL_DONE;
            ff_left_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (pend_take) begin
                cur_valid_reg <= 1'b1;
                slot_reg      <= first_slot;
                ff_left_reg   <= pend_plan.ff_count;
            end else if (emit) begin
                cur_valid_reg <= !last;
                slot_reg      <= slot_next;
                ff_left_reg   <= ff_left_next;
            end
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_take)
            cur_plan_reg <= pend_plan;
        if (emit) begin
            m_tdata_reg <= slot_byte;
            m_tlast_reg <= (slot_reg == SL_TRAIL);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // the closing beat always carries the trailing byte
    a_last_is_trail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_tdata_reg == BYTE_TRAIL)
        else $error("closing beat without trailing byte");

    // a run of FF bytes never starts with nothing left to send
    a_ff_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg && slot_reg == SL_FF |-> ff_left_reg != '0)
        else $error("FF slot with empty count");

    // the start code is always followed by the NAL header
    a_sc_then_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && slot_reg == SL_SC3 |=> cur_valid_reg && slot_reg == SL_HDR0)
        else $error("start code not followed by header");

    // a new plan is only taken once the current one has finished
    a_take_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_take && cur_valid_reg |-> emit && slot_next == SL_DONE)
        else $error("plan overwritten before done");

endmodule
